/* src/pbf_pkg.sv */
package pbf_pkg;

  // Command codes carried in the cmd field of a request.
  localparam logic [2:0] CMD_PUSH       = 3'd0;
  localparam logic [2:0] CMD_POP        = 3'd1;
  localparam logic [2:0] CMD_PEEK       = 3'd2;
  localparam logic [2:0] CMD_FLUSH      = 3'd3;
  localparam logic [2:0] CMD_PUSH_CHECK = 3'd4;
  localparam logic [2:0] CMD_POP_CHECK  = 3'd5;
  localparam logic [2:0] CMD_ENSURE     = 3'd6;

  // Status codes returned with every result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_UNDERRUN = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_ECHK  = 4'b0100,
    S_EREAD = 4'b1000
  } state_t;

endpackage

/* src/pbf_cmd_if.sv */
interface pbf_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_in;
  logic [7:0] req_count;

  modport source (output valid, output cmd, output data_in, output req_count, input ready);
  modport sink   (input valid, input cmd, input data_in, input req_count, output ready);
endinterface

/* src/pbf_result_if.sv */
interface pbf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [8:0] fill_count;
  logic [2:0] status;

  modport source (output valid, output data_out, output fill_count, output status, input ready);
  modport sink   (input valid, input data_out, input fill_count, input status, output ready);
endinterface

/* src/pbf_ram.sv */
module pbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/packet_byte_fifo.sv */
// Circular byte FIFO with packet-aware space management.
// Requests arrive on cmd_chan (valid/ready); each one yields exactly one
// result on result_chan, in request order. A result carries the byte that
// was popped or peeked (zero otherwise), the fill level after the command,
// and a status code.
// Push, flush and the two burst checks register their result directly; pop
// and peek wait on the registered read of the byte memory first; ensure takes
// one read of the length byte and one decision for every packet dropped from
// the head, through the single read port of the memory.
// Push, flush and the checks can be issued every cycle while the result slot
// is free; pop, peek and ensure block new requests until their result is
// registered. The result sits in an output register, so a new request is
// taken in the same cycle that the previous result is being taken.
// When the receiver stalls, the result is held and cmd_chan.ready stays low
// until the result slot is free.
// Reset clears the pointers and the fill level; the byte memory is not
// cleared, since no entry is read before it has been written.
module packet_byte_fifo
  import pbf_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  pbf_cmd_if.sink       cmd_chan,
  pbf_result_if.source  result_chan
);

  localparam int PW = $clog2(DEPTH);
  localparam int HW = $clog2(DEPTH + 1);
  // Compare width: holds the fill level, a request count and their sum.
  localparam int CW = ((HW > 8) ? HW : 8) + 1;
  // Pointer sum width: a pointer plus a packet length.
  localparam int SW = ((PW > 8) ? PW : 8) + 1;

  state_t        state, state_next;
  logic [PW-1:0] read_ptr, read_ptr_next;
  logic [PW-1:0] write_ptr, write_ptr_next;
  logic [HW-1:0] held, held_next;
  logic [7:0]    want, want_next;     // free space that ensure must reach
  logic          peek_only, peek_only_next;

  logic          out_valid, out_valid_next;
  logic [7:0]    out_data, out_data_next;
  logic [8:0]    out_fill, out_fill_next;
  logic [2:0]    out_status, out_status_next;

  logic          ram_we;
  logic [7:0]    ram_rdata;

  logic          accept;
  logic          slot_free;
  logic [CW-1:0] held_w, req_w, free_w, len_w, held1_w, fill_w;
  logic [HW-1:0] held1;
  logic [PW-1:0] rp1;
  logic [SW-1:0] rp_sum;

  pbf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (cmd_chan.data_in),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  // The result slot can take a new result when empty or being drained now.
  assign slot_free      = !out_valid || result_chan.ready;
  assign cmd_chan.ready = (state == S_IDLE) && slot_free;
  assign accept         = cmd_chan.valid && cmd_chan.ready;

  assign result_chan.valid      = out_valid;
  assign result_chan.data_out   = out_data;
  assign result_chan.fill_count = out_fill;
  assign result_chan.status     = out_status;

  // Arithmetic shared by the command decode, the pop read and the ensure loop.
  assign held_w  = CW'(held);
  assign req_w   = CW'(cmd_chan.req_count);
  assign free_w  = CW'(DEPTH) - held_w;
  assign held1   = held - HW'(1);
  assign held1_w = CW'(held1);
  assign len_w   = CW'(ram_rdata);
  assign rp1     = (read_ptr == PW'(DEPTH - 1)) ? '0 : read_ptr + PW'(1);
  // Used only when the packet length fits in what is held, so one wrap suffices.
  assign rp_sum  = SW'(rp1) + SW'(ram_rdata);

  always_comb begin
    state_next      = state;
    read_ptr_next   = read_ptr;
    write_ptr_next  = write_ptr;
    held_next       = held;
    want_next       = want;
    peek_only_next  = peek_only;
    out_valid_next  = out_valid && !result_chan.ready;
    out_data_next   = out_data;
    out_fill_next   = out_fill;
    out_status_next = out_status;
    ram_we          = 1'b0;
    fill_w          = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          out_data_next   = '0;
          out_status_next = ST_OK;
          case (cmd_chan.cmd)
            CMD_PUSH: begin
              if (held == HW'(DEPTH)) begin
                read_ptr_next   = '0;
                write_ptr_next  = '0;
                held_next       = '0;
                out_status_next = ST_OVERFLOW;
              end else begin
                ram_we         = 1'b1;
                write_ptr_next = (write_ptr == PW'(DEPTH - 1)) ? '0 : write_ptr + PW'(1);
                held_next      = held + HW'(1);
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (held == '0) begin
                out_status_next = ST_EMPTY;
              end else begin
                // The head byte is on its way out of the memory.
                out_valid_next = 1'b0;
                peek_only_next = (cmd_chan.cmd == CMD_PEEK);
                state_next     = S_READ;
              end
            end
            CMD_FLUSH: begin
              read_ptr_next  = '0;
              write_ptr_next = '0;
              held_next      = '0;
            end
            CMD_PUSH_CHECK: begin
              if (held_w + req_w > CW'(DEPTH)) begin
                read_ptr_next   = '0;
                write_ptr_next  = '0;
                held_next       = '0;
                out_status_next = ST_OVERFLOW;
              end
            end
            CMD_POP_CHECK: begin
              if (req_w > held_w) begin
                read_ptr_next   = '0;
                write_ptr_next  = '0;
                held_next       = '0;
                out_status_next = ST_UNDERRUN;
              end
            end
            CMD_ENSURE: begin
              if (req_w > CW'(DEPTH)) begin
                out_status_next = ST_REJECTED;
              end else begin
                out_valid_next = 1'b0;
                want_next      = cmd_chan.req_count;
                state_next     = S_ECHK;
              end
            end
            default: begin
              // The unused command code leaves the buffer as it is.
            end
          endcase
          if (state_next == S_IDLE) begin
            fill_w        = CW'(held_next);
            out_fill_next = fill_w[8:0];
          end
        end
      end

      S_READ: begin
        out_valid_next  = 1'b1;
        out_data_next   = ram_rdata;
        out_status_next = ST_OK;
        if (!peek_only) begin
          read_ptr_next = rp1;
          held_next     = held1;
        end
        fill_w        = CW'(held_next);
        out_fill_next = fill_w[8:0];
        state_next    = S_IDLE;
      end

      S_ECHK: begin
        if ((free_w < CW'(want)) && (held != '0)) begin
          // The length byte at the head is read in this cycle.
          state_next = S_EREAD;
        end else begin
          out_valid_next  = 1'b1;
          out_data_next   = '0;
          out_status_next = ST_OK;
          fill_w          = held_w;
          out_fill_next   = fill_w[8:0];
          state_next      = S_IDLE;
        end
      end

      S_EREAD: begin
        if (len_w > held1_w) begin
          // A length that runs past the data held empties the buffer.
          read_ptr_next  = '0;
          write_ptr_next = '0;
          held_next      = '0;
        end else begin
          read_ptr_next = (rp_sum >= SW'(DEPTH)) ? PW'(rp_sum - SW'(DEPTH)) : PW'(rp_sum);
          held_next     = held1 - HW'(ram_rdata);
        end
        state_next = S_ECHK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      read_ptr  <= '0;
      write_ptr <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      read_ptr  <= read_ptr_next;
      write_ptr <= write_ptr_next;
      held      <= held_next;
      out_valid <= out_valid_next;
    end
    want       <= want_next;
    peek_only  <= peek_only_next;
    out_data   <= out_data_next;
    out_fill   <= out_fill_next;
    out_status <= out_status_next;
  end

endmodule
